// ===== hdl/shabc_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 block compression engine.
package shabc_pkg;

   localparam int WordBits      = 32;
   localparam int HashWords     = 8;
   localparam int BlockWords    = 16;
   localparam int ROUNDS_DEFAULT = 64;
   localparam int KEntries      = 64;
   localparam int KIdxBits      = $clog2(KEntries);
   localparam int DigestIdxBits = $clog2(HashWords);
   localparam int WordCntBits   = $clog2(BlockWords);

   typedef logic [WordBits-1:0] word_type;
   typedef word_type [HashWords-1:0] hash_type;

   // Schedule window control from the sequencer.
   typedef struct packed {
      logic shift_in;   // take a message word from the request channel
      logic expand;     // advance one round, appending the next expanded word
   } sched_ctl_type;

   localparam hash_type INIT_HASH = '{
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   function automatic word_type ror(word_type x, int n);
      return (x >> n) | (x << (WordBits - n));
   endfunction

   function automatic word_type big_sigma0(word_type x);
      return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
   endfunction

   function automatic word_type big_sigma1(word_type x);
      return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
   endfunction

   function automatic word_type small_sigma0(word_type x);
      return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(word_type x);
      return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type round_k(logic [KIdxBits-1:0] idx);
      word_type k;
      unique case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

// ===== hdl/shabc_if.sv =====
// Request and response channel interfaces of the SHA-256 block compression engine.
interface shabc_req_if;
   logic                           valid;
   logic                           ready;
   logic [shabc_pkg::WordBits-1:0] msg_word;
   logic                           start_message;
   logic                           final_block;

   modport source (output valid, output msg_word, output start_message,
                   output final_block, input ready);
   modport sink   (input valid, input msg_word, input start_message,
                   input final_block, output ready);
endinterface

interface shabc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [shabc_pkg::WordBits-1:0]      digest_word;
   logic [shabc_pkg::DigestIdxBits-1:0] digest_index;
   logic                                digest_last;

   modport source (output valid, output digest_word, output digest_index,
                   output digest_last, input ready);
   modport sink   (input valid, input digest_word, input digest_index,
                   input digest_last, output ready);
endinterface

// ===== hdl/shabc_sched.sv =====
// Message schedule window: sixteen-word shift line with in-place expansion.
module shabc_sched (
   input  logic                     clock,
   input  shabc_pkg::sched_ctl_type ctl,
   input  shabc_pkg::word_type      msg_word,
   output shabc_pkg::word_type      w_cur
);
   import shabc_pkg::*;

   // Entry 0 is the oldest word, that is w[t] of the current round.
   word_type win_ff [BlockWords];
   word_type win_in [BlockWords];
   word_type expanded;

   assign expanded = win_ff[0] + small_sigma0(win_ff[1]) + win_ff[9]
                   + small_sigma1(win_ff[14]);
   assign w_cur    = win_ff[0];

   always_comb begin
      for (int i = 0; i < BlockWords - 1; i++) begin
         win_in[i] = win_ff[i+1];
      end
      win_in[BlockWords-1] = ctl.shift_in ? msg_word : expanded;
   end

   always_ff @(posedge clock) begin
      if (ctl.shift_in || ctl.expand) begin
         win_ff <= win_in;
      end
   end

endmodule

// ===== hdl/shabc_round.sv =====
// One SHA-256 compression round over the working variables a..h.
module shabc_round (
   input  shabc_pkg::hash_type v_cur,
   input  shabc_pkg::word_type w_cur,
   input  shabc_pkg::word_type k_cur,
   output shabc_pkg::hash_type v_next
);
   import shabc_pkg::*;

   word_type ch;
   word_type maj;
   word_type t1;
   word_type t2;

   assign ch  = (v_cur[4] & v_cur[5]) ^ (~v_cur[4] & v_cur[6]);
   assign maj = (v_cur[0] & v_cur[1]) ^ (v_cur[0] & v_cur[2]) ^ (v_cur[1] & v_cur[2]);
   assign t1  = v_cur[7] + big_sigma1(v_cur[4]) + ch + k_cur + w_cur;
   assign t2  = big_sigma0(v_cur[0]) + maj;

   always_comb begin
      v_next[7] = v_cur[6];
      v_next[6] = v_cur[5];
      v_next[5] = v_cur[4];
      v_next[4] = v_cur[3] + t1;
      v_next[3] = v_cur[2];
      v_next[2] = v_cur[1];
      v_next[1] = v_cur[0];
      v_next[0] = t1 + t2;
   end

endmodule

// ===== hdl/sha256_block_compression_top.sv =====
// Top level of the SHA-256 block compression engine: sequencer, chaining value, digest output.
// The host streams padded message words, one request per 32-bit big-endian word, and a
// word may be taken every cycle while a block is being filled. After the sixteenth word the
// engine drops ready while it runs the ROUNDS rounds in the ROUND state through a single
// shared round unit and schedule expander, then adds the working variables into the
// chaining value in the ADD state. For a final block the eight digest words follow, H0
// first, one per accepted response, and ready stays low until the last one is taken. A
// request with start_message set reloads the initial hash values and begins a new block
// with that word; without it, blocks chain on.
module sha256_block_compression_top #(
   parameter int ROUNDS = shabc_pkg::ROUNDS_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   shabc_req_if.sink    req_chan,
   shabc_rsp_if.source  rsp_chan
);
   import shabc_pkg::*;

   localparam int RoundBits = $clog2(ROUNDS);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } state_type;

   state_type                state_ff, state_in;
   hash_type                 chain_ff, chain_in;
   hash_type                 vars_ff, vars_in;
   logic [WordCntBits-1:0]   word_cnt_ff, word_cnt_in;
   logic                     final_ff, final_in;
   logic [RoundBits-1:0]     round_ff, round_in;
   logic [DigestIdxBits-1:0] emit_idx_ff, emit_idx_in;

   logic                     req_fire;
   logic                     rsp_fire;
   logic [WordCntBits-1:0]   word_base;
   sched_ctl_type            sched_ctl;
   word_type                 w_cur;
   hash_type                 vars_round;

   assign req_chan.ready = (state_ff == ST_LOAD);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;
   assign word_base      = req_chan.start_message ? '0 : word_cnt_ff;

   assign sched_ctl.shift_in = req_fire;
   assign sched_ctl.expand   = (state_ff == ST_ROUND);

   shabc_sched u_sched (
      .clock    (clock),
      .ctl      (sched_ctl),
      .msg_word (req_chan.msg_word),
      .w_cur    (w_cur)
   );

   shabc_round u_round (
      .v_cur  (vars_ff),
      .w_cur  (w_cur),
      .k_cur  (round_k(round_ff)),
      .v_next (vars_round)
   );

   assign rsp_chan.valid        = (state_ff == ST_EMIT);
   assign rsp_chan.digest_word  = chain_ff[emit_idx_ff];
   assign rsp_chan.digest_index = emit_idx_ff;
   assign rsp_chan.digest_last  = (emit_idx_ff == DigestIdxBits'(HashWords - 1));

   always_comb begin
      state_in    = state_ff;
      chain_in    = chain_ff;
      vars_in     = vars_ff;
      word_cnt_in = word_cnt_ff;
      final_in    = final_ff;
      round_in    = round_ff;
      emit_idx_in = emit_idx_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (req_chan.start_message) begin
                  chain_in = INIT_HASH;
               end
               final_in    = (final_ff && !req_chan.start_message) || req_chan.final_block;
               word_cnt_in = word_base + 1'b1;
               if (word_base == WordCntBits'(BlockWords - 1)) begin
                  vars_in  = chain_in;
                  round_in = '0;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            vars_in  = vars_round;
            round_in = round_ff + 1'b1;
            if (round_ff == RoundBits'(ROUNDS - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < HashWords; i++) begin
               chain_in[i] = chain_ff[i] + vars_ff[i];
            end
            if (final_ff) begin
               final_in    = 1'b0;
               emit_idx_in = '0;
               state_in    = ST_EMIT;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               emit_idx_in = emit_idx_ff + 1'b1;
               if (rsp_chan.digest_last) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         chain_ff    <= INIT_HASH;
         vars_ff     <= '0;
         word_cnt_ff <= '0;
         final_ff    <= 1'b0;
         round_ff    <= '0;
         emit_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         chain_ff    <= chain_in;
         vars_ff     <= vars_in;
         word_cnt_ff <= word_cnt_in;
         final_ff    <= final_in;
         round_ff    <= round_in;
         emit_idx_ff <= emit_idx_in;
      end
   end

endmodule

// ===== hdl/shabc_check.sv =====
// Port-level checks of the SHA-256 block compression engine and their binding.
module shabc_check (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_word,
   input logic [2:0]  rsp_index,
   input logic        rsp_last
);

   // No request is taken while digest words are going out.
   a_no_req_during_digest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while digest output is active");

   a_last_on_eighth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_index == 3'd7)))
      else $error("digest_last does not match digest_index");

   // Digest words follow each other without a gap, index rising by one.
   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=>
         (rsp_valid && (rsp_index == 3'($past(rsp_index) + 3'd1))))
      else $error("digest sequence broken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_word) && $stable(rsp_index)))
      else $error("stalled response changed");

endmodule

bind sha256_block_compression_top shabc_check u_shabc_check (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_word  (rsp_chan.digest_word),
   .rsp_index (rsp_chan.digest_index),
   .rsp_last  (rsp_chan.digest_last)
);
